/* rtl/lsa_pkg.sv */
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types, codes and constants for the arithmetic stack block.
// ----------------------------------------------------------------------------
package lsa_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_RDTOP  = 3'd2,
        ACT_RDBOT  = 3'd3,
        ACT_ADD    = 3'd4,
        ACT_SUB    = 3'd5,
        ACT_MUL    = 3'd6,
        ACT_DIV    = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FEW     = 3'd3,
        ST_DIVZERO = 3'd4,
        ST_RANGE   = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] push_value;
        logic [9:0]         position;
    } request_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         status;
        logic [10:0]        occupancy;
    } result_t;

    // control from sequencer to the shared arithmetic unit
    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } alu_ctrl_t;

endpackage

/* rtl/lsa_alu.sv */
// ----------------------------------------------------------------------------
// lsa_alu
// Shared iterative arithmetic unit: add, subtract, shift-add multiply and
// restoring floor divide, one bit per cycle for multiply and divide.
// ----------------------------------------------------------------------------
module lsa_alu
(
    input  logic               clk,
    input  logic               rst_n,
    input  lsa_pkg::alu_ctrl_t ctrl,
    input  logic [31:0]        a,
    input  logic [31:0]        b,
    output logic               done,
    output logic [31:0]        y
);

    logic        run_reg, run_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  op_reg, op_next;
    logic [31:0] acc_reg, acc_next;     // product or remainder
    logic [31:0] sh_reg, sh_next;       // multiplier or dividend/quotient
    logic [31:0] b_reg, b_next;         // multiplicand or divisor magnitude
    logic        nneg_reg, nneg_next;
    logic        dneg_reg, dneg_next;
    logic        fin_reg, fin_next;
    logic [31:0] y_reg, y_next;
    logic [32:0] trial;
    logic [31:0] rem1;
    logic [31:0] q;
    logic [31:0] qpos;

    assign trial = {acc_reg, sh_reg[31]} - {1'b0, b_reg};
    assign rem1  = {acc_reg[30:0], sh_reg[31]};
    assign qpos  = sh_reg;

    // sign fixup for floor semantics
    always_comb
    begin
        q = qpos;
        if (nneg_reg != dneg_reg)
        begin
            q = -qpos;
            if (acc_reg != 32'd0)
            begin
                q = q - 32'd1;
            end
        end
    end

    // sequencing of the shared unit
    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        b_next    = b_reg;
        nneg_next = nneg_reg;
        dneg_next = dneg_reg;
        fin_next  = 1'b0;
        y_next    = y_reg;
        if (ctrl.start)
        begin
            op_next   = ctrl.op;
            nneg_next = a[31];
            dneg_next = b[31];
            cnt_next  = 6'd0;
            case (ctrl.op)
                lsa_pkg::ACT_ADD:
                begin
                    y_next   = a + b;
                    fin_next = 1'b1;
                end
                lsa_pkg::ACT_SUB:
                begin
                    y_next   = a - b;
                    fin_next = 1'b1;
                end
                lsa_pkg::ACT_MUL:
                begin
                    run_next = 1'b1;
                    acc_next = 32'd0;
                    sh_next  = b;
                    b_next   = a;
                end
                default:
                begin
                    run_next = 1'b1;
                    acc_next = 32'd0;
                    sh_next  = a[31] ? -a : a;
                    b_next   = b[31] ? -b : b;
                end
            endcase
        end
        else if (run_reg)
        begin
            if (cnt_reg == 6'd32)
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
                y_next   = (op_reg == lsa_pkg::ACT_MUL) ? acc_reg : q;
            end
            else
            begin
                cnt_next = cnt_reg + 6'd1;
                if (op_reg == lsa_pkg::ACT_MUL)
                begin
                    acc_next = (acc_reg << 1) + (sh_reg[31] ? b_reg : 32'd0);
                    sh_next  = sh_reg << 1;
                end
                else if (!trial[32])
                begin
                    acc_next = trial[31:0];
                    sh_next  = {sh_reg[30:0], 1'b1};
                end
                else
                begin
                    acc_next = rem1;
                    sh_next  = {sh_reg[30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            run_reg <= run_next;
            fin_reg <= fin_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        acc_reg  <= acc_next;
        sh_reg   <= sh_next;
        b_reg    <= b_next;
        nneg_reg <= nneg_next;
        dneg_reg <= dneg_next;
        y_reg    <= y_next;
    end

    assign done = fin_reg;
    assign y    = y_reg;

    a_no_start_while_run: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !run_reg)
        else $error("alu start while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 6'd32)
        else $error("alu counter overrun");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("alu done held");

endmodule

/* rtl/lifo_stack_with_arithmetic_top.sv */
// ----------------------------------------------------------------------------
// lifo_stack_with_arithmetic_top
// Bounded stack of signed words with push, pop, indexed reads and in-place
// add, subtract, multiply and floor divide.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// through the single result strobe, which the receiver must take that cycle.
// Push and any request refused at once (full, empty, too few operands, out of
// range) go straight to completion; pop and reads wait for one registered
// memory read; add and subtract make two operand reads, one unit pass and one
// write-back; divide by zero ends after the operand reads; multiply and divide
// last as long as the shared shift-add/restoring unit takes, working one bit
// per cycle. The strobe comes in the last busy cycle of a request.
// No clearing pass is needed after reset.
module lifo_stack_with_arithmetic_top
#(
    parameter int DEPTH = lsa_pkg::DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lsa_pkg::request_t request,
    output logic              busy,
    output logic              strobe,
    output lsa_pkg::result_t  result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW + 1 > 10) ? CW + 1 : 10;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD1   = 7'b0000010,
        S_RD2   = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_ALU   = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [2:0]        act_reg;
    logic [31:0]       pval_reg;
    logic [31:0]       top_reg;
    logic [31:0]       res_reg, res_next;
    logic [2:0]        st_reg, st_next;
    logic              strobe_reg, strobe_next;
    logic [31:0]       mem [DEPTH];
    logic [31:0]       rdata_reg;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [PW-1:0]     pos_ext;
    logic [CW-1:0]     rd_idx;
    logic              accept;
    lsa_pkg::alu_ctrl_t actl;
    logic              alu_done;
    logic [31:0]       alu_y;

    assign pos_ext = PW'(request.position);
    assign accept  = start && !busy;

    // stack memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    lsa_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (actl),
        .a     (rdata_reg),
        .b     (top_reg),
        .done  (alu_done),
        .y     (alu_y)
    );

    // read index for the request being accepted
    always_comb
    begin
        rd_idx = count_reg - CW'(1);
        case (request.action)
            lsa_pkg::ACT_RDTOP: rd_idx = count_reg - CW'(1) - CW'(request.position);
            lsa_pkg::ACT_RDBOT: rd_idx = CW'(request.position);
            default:            rd_idx = count_reg - CW'(1);
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        res_next    = res_reg;
        st_next     = st_reg;
        strobe_next = 1'b0;
        we          = 1'b0;
        waddr       = count_reg[AW-1:0];
        wdata       = pval_reg;
        re          = 1'b0;
        raddr       = rd_idx[AW-1:0];
        actl.start  = 1'b0;
        actl.op     = act_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = 32'd0;
                    st_next    = lsa_pkg::ST_OK;
                    state_next = S_DONE;
                    case (request.action)
                        lsa_pkg::ACT_PUSH:
                        begin
                            if ({1'b0, count_reg} >= (CW+1)'(DEPTH))
                                st_next = lsa_pkg::ST_FULL;
                            else
                            begin
                                we         = 1'b1;
                                wdata      = request.push_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        lsa_pkg::ACT_POP:
                        begin
                            if (count_reg == '0)
                                st_next = lsa_pkg::ST_EMPTY;
                            else
                            begin
                                re         = 1'b1;
                                state_next = S_RD1;
                            end
                        end
                        lsa_pkg::ACT_RDTOP, lsa_pkg::ACT_RDBOT:
                        begin
                            if (pos_ext >= PW'(count_reg))
                                st_next = lsa_pkg::ST_RANGE;
                            else
                            begin
                                re         = 1'b1;
                                state_next = S_RD1;
                            end
                        end
                        default:
                        begin
                            if (count_reg < CW'(2))
                                st_next = lsa_pkg::ST_FEW;
                            else
                            begin
                                re         = 1'b1;
                                state_next = S_RD2;
                            end
                        end
                    endcase
                end
            end
            S_RD1:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                res_next = rdata_reg;
                if (act_reg == lsa_pkg::ACT_POP)
                    count_next = count_reg - CW'(1);
                state_next = S_DONE;
            end
            S_RD2:
            begin
                // top word is in the read register now; fetch the second word
                re         = 1'b1;
                raddr      = AW'(count_reg - CW'(2));
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // second word in the read register, top word in top_reg
                if (act_reg == lsa_pkg::ACT_DIV && top_reg == 32'd0)
                begin
                    st_next    = lsa_pkg::ST_DIVZERO;
                    res_next   = 32'd0;
                    state_next = S_DONE;
                end
                else
                begin
                    actl.start = 1'b1;
                    state_next = S_ALU;
                end
            end
            S_ALU:
            begin
                if (alu_done)
                begin
                    res_next   = alu_y;
                    we         = 1'b1;
                    waddr      = AW'(count_reg - CW'(2));
                    wdata      = alu_y;
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    // request and operand capture
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        st_reg  <= st_next;
        if (state_reg == S_IDLE && accept)
        begin
            act_reg  <= request.action;
            pval_reg <= request.push_value;
        end
        if (state_reg == S_RD2)
            top_reg <= rdata_reg;
    end

    assign busy   = (state_reg != S_IDLE) || strobe_reg;
    assign strobe = strobe_reg;
    assign result.result_value = res_reg;
    assign result.status       = st_reg;
    assign result.occupancy    = 11'(count_reg);

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} <= (CW+1)'(DEPTH))
        else $error("occupancy over depth");
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == S_DONE))
        else $error("strobe without completion");

endmodule
